[rtl/fcpg_pkg.sv]
// Package: constants, types and sample tables of the false-colour palette generator.
`timescale 1ns / 1ps
package fcpg_pkg;

	localparam int MaxColors = 256;
	localparam int FracBits  = 16;
	localparam int OneVal    = 1 << FracBits;

	// t carries one bit above the fraction so that 1.0 fits
	localparam int TW = FracBits + 1;

	typedef enum logic [2:0] {
		SCH_GRAY     = 3'd0,
		SCH_HEAT     = 3'd1,
		SCH_COOLWARM = 3'd2,
		SCH_JET      = 3'd3,
		SCH_VIRIDIS  = 3'd4,
		SCH_PLASMA   = 3'd5,
		SCH_INFERNO  = 3'd6,
		SCH_TURBO    = 3'd7
	} scheme_t;

	localparam logic CFG_SCHEME = 1'b0;
	localparam logic CFG_COUNT  = 1'b1;

	typedef logic [19:0] samp_t;
	typedef samp_t rgb_samp_t [3];

	// Sample lookup, one colour triple per table row.
	function automatic rgb_samp_t sample(input scheme_t s, input logic [3:0] k);
		rgb_samp_t r;
		r[0] = '0; r[1] = '0; r[2] = '0;
		case (s)
			SCH_VIRIDIS: begin
				case (k)
					4'd0: r = '{20'd267004, 20'd4874,   20'd329415};
					4'd1: r = '{20'd282623, 20'd140926, 20'd457517};
					4'd2: r = '{20'd253935, 20'd265254, 20'd529983};
					4'd3: r = '{20'd206756, 20'd371758, 20'd553117};
					4'd4: r = '{20'd163625, 20'd471133, 20'd558148};
					4'd5: r = '{20'd127568, 20'd566949, 20'd550556};
					4'd6: r = '{20'd134692, 20'd658636, 20'd517649};
					4'd7: r = '{20'd266941, 20'd748751, 20'd440573};
					4'd8: r = '{20'd477504, 20'd821444, 20'd318195};
					4'd9: r = '{20'd741388, 20'd873449, 20'd149561};
					default: r = '{20'd993248, 20'd906157, 20'd143936};
				endcase
			end
			SCH_PLASMA: begin
				case (k)
					4'd0: r = '{20'd50383,  20'd29803,  20'd527975};
					4'd1: r = '{20'd287675, 20'd10384,  20'd627642};
					4'd2: r = '{20'd490384, 20'd7351,   20'd658371};
					4'd3: r = '{20'd652261, 20'd129972, 20'd615419};
					4'd4: r = '{20'd783654, 20'd283888, 20'd523240};
					4'd5: r = '{20'd881443, 20'd451734, 20'd411479};
					4'd6: r = '{20'd951546, 20'd628268, 20'd300267};
					4'd7: r = '{20'd987622, 20'd809575, 20'd218070};
					default: r = '{20'd987919, 20'd991438, 20'd216902};
				endcase
			end
			SCH_INFERNO: begin
				case (k)
					4'd0: r = '{20'd1462,   20'd466,    20'd13866};
					4'd1: r = '{20'd189503, 20'd18803,  20'd305202};
					4'd2: r = '{20'd408558, 20'd45257,  20'd423292};
					4'd3: r = '{20'd611423, 20'd128054, 20'd425581};
					4'd4: r = '{20'd801663, 20'd281412, 20'd356454};
					4'd5: r = '{20'd930695, 20'd479267, 20'd259636};
					4'd6: r = '{20'd978422, 20'd693448, 20'd176089};
					4'd7: r = '{20'd951585, 20'd906735, 20'd234611};
					default: r = '{20'd988362, 20'd998364, 20'd644924};
				endcase
			end
			default: begin
				case (k)
					4'd0: r = '{20'd189950, 20'd71760,  20'd232170};
					4'd1: r = '{20'd138400, 20'd419420, 20'd696150};
					4'd2: r = '{20'd154820, 20'd638760, 20'd691490};
					4'd3: r = '{20'd386260, 20'd806990, 20'd507750};
					4'd4: r = '{20'd697650, 20'd869790, 20'd247920};
					4'd5: r = '{20'd941880, 20'd751470, 20'd130890};
					4'd6: r = '{20'd983230, 20'd516040, 20'd130420};
					4'd7: r = '{20'd877700, 20'd305830, 20'd180880};
					default: r = '{20'd705840, 20'd15560,  20'd150290};
				endcase
			end
		endcase
		return r;
	endfunction

endpackage

[rtl/fcpg_recip_rom.sv]
// Reciprocal ROM: ceil(2^32 / d) for the ramp divisor, registered output.
`timescale 1ns / 1ps
module fcpg_recip_rom (
	input  logic        clk,
	input  logic [7:0]  divisor,
	output logic [32:0] recip
);
	logic [32:0] recip_d;

	// Value 0 never used (count below two forces t to zero).
	// Each row is a constant, so the loop reduces to a table.
	always_comb begin
		recip_d = '0;
		for (int k = 1; k < 256; k++) begin
			if (divisor == 8'(k)) begin
				recip_d = 33'((64'd4294967296 + 64'(k) - 64'd1) / 64'(k));
			end
		end
	end

	always_ff @(posedge clk) begin
		recip <= recip_d;
	end
endmodule

[rtl/false_color_palette_generator.sv]
// Top level: pipelined false-colour palette generator.
`timescale 1ns / 1ps
// Returns the RGB colour of one palette entry for the configured scheme and
// colour count. A request is taken every cycle while the output is not
// stalled. The six pipeline stages are request capture beside the divisor
// reciprocal lookup, ramp multiply, ramp correction, scheme arithmetic,
// table blend and rounding divide; a single stall signal holds all stages,
// and s_tready follows the output side. Write the registers only while the
// pipeline is empty.
module false_color_palette_generator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] entry_index
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // [7:0] entry_out, [23:8] red, [39:24] green, [55:40] blue
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [8:0]  cfg_data
);
	import fcpg_pkg::*;

	// Divide by 33 and by 34 through reciprocal multiplication; exact for
	// every operand of the heat ramp (below 2^22).
	function automatic logic [16:0] div33(input logic [21:0] x);
		logic [45:0] pr;
		pr = 46'(x) * 46'(22'd4067204);
		return 17'(pr >> 27);
	endfunction

	function automatic logic [16:0] div34(input logic [21:0] x);
		logic [41:0] pr;
		pr = 42'(x[21:1]) * 42'(21'd1973791);
		return 17'(pr >> 25);
	endfunction

	scheme_t     scheme_q;
	logic [8:0]  count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scheme_q <= SCH_GRAY;
			count_q  <= 9'd256;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_SCHEME: scheme_q <= scheme_t'(cfg_data[2:0]);
				default:    count_q  <= cfg_data;
			endcase
		end
	end

	// Effective count clamped to MaxColors; divisor is count-1, or zero below two.
	logic [8:0] cnt_eff;
	logic       cnt_small;
	logic [7:0] divisor;
	assign cnt_eff   = (count_q > 9'(MaxColors)) ? 9'(MaxColors) : count_q;
	assign cnt_small = (cnt_eff < 9'd2);
	assign divisor   = cnt_small ? 8'd0 : 8'(cnt_eff - 9'd1);

	// Advance whenever the output stage is empty or being taken.
	logic adv;
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	logic [32:0] recip;
	fcpg_recip_rom u_rom (.clk(clk), .divisor(divisor), .recip(recip));
	// ROM registers every cycle; hold its value on stall.
	logic [32:0] recip_h_q;
	logic        adv_d_q;
	logic [32:0] recip_v;
	assign recip_v = adv_d_q ? recip : recip_h_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) adv_d_q <= 1'b1;
		else         adv_d_q <= adv;
	end
	always_ff @(posedge clk) begin
		recip_h_q <= recip_v;
	end

	// Stage 1: capture request
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [7:0] idx_s1, idx_s2, idx_s3, idx_s4, idx_s5, idx_s6;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
			v_s4 <= 1'b0; v_s5 <= 1'b0; v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid; v_s2 <= v_s1; v_s3 <= v_s2;
			v_s4 <= v_s3;     v_s5 <= v_s4; v_s6 <= v_s5;
		end
	end

	logic [1:0] tk_s1; // 0 zero, 1 one, 2 divide
	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s1 <= s_tdata;
			if (cnt_small)                       tk_s1 <= 2'd0;
			else if ({1'b0, s_tdata} >= cnt_eff - 9'd1) tk_s1 <= 2'd1;
			else                                 tk_s1 <= 2'd2;
		end
	end

	// Stage 2: t estimate = (idx * 2^16 * recip) >> 32, recip rounded up
	logic [40:0] prod_s2;
	logic [1:0]  tk_s2;
	logic [7:0]  div_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2 <= 41'(idx_s1) * 41'(recip_v);
			tk_s2   <= tk_s1;
			div_s2  <= divisor;
			idx_s2  <= idx_s1;
		end
	end

	// Stage 3: correct estimate (may be one high) and form t
	logic [TW-1:0] t_s3;
	logic [24:0]   num;
	logic [16:0]   te;
	logic [24:0]   chk;
	assign te  = 17'(prod_s2 >> 16);
	assign num = {1'b0, idx_s2, 16'd0};
	assign chk = 25'(te) * 25'(div_s2);
	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s3 <= idx_s2;
			case (tk_s2)
				2'd0:    t_s3 <= '0;
				2'd1:    t_s3 <= TW'(OneVal);
				default: t_s3 <= (chk > num) ? TW'(te - 17'd1) : TW'(te);
			endcase
		end
	end

	// Stage 4: scheme arithmetic and table segment select
	logic [16:0] r_s4, g_s4, b_s4;
	logic        tab_s4;
	logic [3:0]  seg_s4;
	logic [16:0] fr_s4;
	scheme_t     sch_s4;
	logic [23:0] t100;
	logic [20:0] t8, t4;
	logic [33:0] cw;
	logic [20:0] p;
	logic [3:0]  nm1;
	logic [16:0] fr;
	logic [3:0]  sg;
	always_comb begin
		t100 = 24'(t_s3) * 24'd100;
		t8   = 21'(t_s3) << 3;
		t4   = 21'(t_s3) << 2;
		cw   = (34'(t_s3) * 34'(17'(OneVal) - t_s3)) << 1;
		nm1  = (scheme_q == SCH_VIRIDIS) ? 4'd10 : 4'd8;
		p    = 21'(t_s3) * 21'(nm1);
		sg   = 4'(p >> 16);
		fr   = {1'b0, p[15:0]};
		if (sg >= nm1) begin
			sg = nm1 - 4'd1;
			fr = 17'(OneVal);
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s4 <= idx_s3;
			sch_s4 <= scheme_q;
			seg_s4 <= sg;
			fr_s4  <= fr;
			tab_s4 <= scheme_q inside {SCH_VIRIDIS, SCH_PLASMA, SCH_INFERNO, SCH_TURBO};
			r_s4 <= '0; g_s4 <= '0; b_s4 <= '0;
			case (scheme_q)
				SCH_GRAY: begin
					r_s4 <= t_s3; g_s4 <= t_s3; b_s4 <= t_s3;
				end
				SCH_HEAT: begin
					if (t100 < 24'(33 * OneVal)) begin
						r_s4 <= div33(22'(t100));
					end else if (t100 < 24'(67 * OneVal)) begin
						r_s4 <= 17'(OneVal);
						g_s4 <= div34(22'(t100 - 24'(33 * OneVal)));
					end else begin
						r_s4 <= 17'(OneVal); g_s4 <= 17'(OneVal);
						b_s4 <= div33(22'(t100 - 24'(67 * OneVal)));
					end
				end
				SCH_COOLWARM: begin
					r_s4 <= t_s3;
					g_s4 <= 17'(cw >> 16);
					b_s4 <= 17'(OneVal) - t_s3;
				end
				SCH_JET: begin
					if (t8 < 21'(OneVal)) begin
						b_s4 <= 17'(21'(OneVal / 2) + t4);
					end else if (t8 < 21'(3 * OneVal)) begin
						g_s4 <= 17'(t4 - 21'(OneVal / 2));
						b_s4 <= 17'(OneVal);
					end else if (t8 < 21'(5 * OneVal)) begin
						r_s4 <= 17'(t4 - 21'(3 * OneVal / 2));
						g_s4 <= 17'(OneVal);
						b_s4 <= 17'(21'(OneVal) - (t4 - 21'(3 * OneVal / 2)));
					end else if (t8 < 21'(7 * OneVal)) begin
						r_s4 <= 17'(OneVal);
						g_s4 <= 17'(21'(OneVal) - (t4 - 21'(5 * OneVal / 2)));
					end else begin
						r_s4 <= 17'(21'(OneVal) - (t4 - 21'(7 * OneVal / 2)));
					end
				end
				default: ;
			endcase
		end
	end

	// Stage 5: table blend a*(1-f) + b*f
	rgb_samp_t sa, sb;
	assign sa = sample(sch_s4, seg_s4);
	assign sb = sample(sch_s4, seg_s4 + 4'd1);
	logic [36:0] bl_s5 [3];
	logic [16:0] pr_s5 [3];
	logic        tab_s5;
	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s5 <= idx_s4;
			tab_s5 <= tab_s4;
			pr_s5[0] <= r_s4; pr_s5[1] <= g_s4; pr_s5[2] <= b_s4;
			for (int c = 0; c < 3; c++) begin
				bl_s5[c] <= 37'(sa[c]) * 37'(17'(OneVal) - fr_s4)
				          + 37'(sb[c]) * 37'(fr_s4);
			end
		end
	end

	// Stage 6: round-half-up divide by one million for table schemes, then saturate.
	// One million is 64 * 15625: drop six bits, then multiply by the
	// rounded-up reciprocal of 15625 (exact for sums below 2^30).
	logic [15:0] q_s6 [3];
	logic [36:0] rs;
	logic [29:0] qx;
	logic [60:0] qp;
	logic [16:0] qv [3];
	logic [16:0] qd;
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			rs = bl_s5[c] + 37'd500000;
			qx = 30'(rs >> 6);
			qp = 61'(qx) * 61'(31'd1125899907);
			qd = 17'(qp >> 44);
			qv[c] = tab_s5 ? qd : pr_s5[c];
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s6 <= idx_s5;
			for (int c = 0; c < 3; c++) begin
				q_s6[c] <= qv[c][16] ? 16'hFFFF : qv[c][15:0];
			end
		end
	end

	assign m_tvalid = v_s6;
	assign m_tdata  = {q_s6[2], q_s6[1], q_s6[0], idx_s6};
endmodule

[rtl/fcpg_checker.sv]
// Checker: port-level properties of the palette generator, bound to the top level.
`timescale 1ns / 1ps
module fcpg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata
);
	import fcpg_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped or changed while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled while output free");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while output stalled");
endmodule

bind false_color_palette_generator fcpg_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

[tb/testbench.sv]
// Testbench for the false-colour palette generator: directed table, then random requests.
`timescale 1ns / 1ps
module testbench;
	import fcpg_pkg::*;

	localparam int LATENCY    = 6;
	localparam int IDLE_LIMIT = 2000;

	// Directed row: scheme and count to apply first, index to request, and an
	// expected colour where it is obvious (chk set), else the predictor decides.
	typedef struct {
		scheme_t    sch;
		logic [8:0] cnt;
		logic [7:0] idx;
		logic       chk;
		logic [15:0] r, g, b;
	} row_t;

	typedef struct packed {
		logic [7:0]  idx;
		logic [15:0] r, g, b;
	} colour_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic        cfg_we = 1'b0;
	logic        cfg_addr = CFG_SCHEME;
	logic [8:0]  cfg_data = '0;

	scheme_t    cur_scheme = SCH_GRAY;
	logic [8:0] cur_count = 9'd256;
	colour_t    pending_colours[$];
	int         mismatches = 0;
	int         idle_cycles = 0;
	int         requests_sent = 0;
	int         colours_seen = 0;
	bit         quiet_spell = 1'b0;
	bit         timed_out = 1'b0;

	false_color_palette_generator u_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Sample rows in millionths, three per row, rows of the selected table.
	function automatic longint unsigned tab_val(scheme_t s, int k, int c);
		int vir[33] = '{267004,4874,329415, 282623,140926,457517, 253935,265254,529983,
			206756,371758,553117, 163625,471133,558148, 127568,566949,550556,
			134692,658636,517649, 266941,748751,440573, 477504,821444,318195,
			741388,873449,149561, 993248,906157,143936};
		int pla[27] = '{50383,29803,527975, 287675,10384,627642, 490384,7351,658371,
			652261,129972,615419, 783654,283888,523240, 881443,451734,411479,
			951546,628268,300267, 987622,809575,218070, 987919,991438,216902};
		int inf[27] = '{1462,466,13866, 189503,18803,305202, 408558,45257,423292,
			611423,128054,425581, 801663,281412,356454, 930695,479267,259636,
			978422,693448,176089, 951585,906735,234611, 988362,998364,644924};
		int tur[27] = '{189950,71760,232170, 138400,419420,696150, 154820,638760,691490,
			386260,806990,507750, 697650,869790,247920, 941880,751470,130890,
			983230,516040,130420, 877700,305830,180880, 705840,15560,150290};
		case (s)
			SCH_VIRIDIS: return vir[k*3+c];
			SCH_PLASMA:  return pla[k*3+c];
			SCH_INFERNO: return inf[k*3+c];
			default:     return tur[k*3+c];
		endcase
	endfunction

	function automatic colour_t palette_colour(scheme_t s, logic [8:0] count, logic [7:0] idx);
		longint unsigned one, t, n, pos, seg, fr, a, b, cnt;
		longint unsigned rgb[3];
		colour_t res;
		one = 64'd1 << FracBits;
		cnt = (count > MaxColors) ? MaxColors : count;
		rgb = '{0, 0, 0};
		if (cnt < 2) t = 0;
		else if (idx >= cnt - 1) t = one;
		else t = idx * one / (cnt - 1);
		case (s)
			SCH_GRAY: rgb = '{t, t, t};
			SCH_HEAT: begin
				if (t*100 < 33*one) rgb[0] = t*100/33;
				else if (t*100 < 67*one) begin
					rgb[0] = one; rgb[1] = (t*100 - 33*one)/34;
				end else begin
					rgb[0] = one; rgb[1] = one; rgb[2] = (t*100 - 67*one)/33;
				end
			end
			SCH_COOLWARM: begin
				rgb[0] = t; rgb[1] = 2*t*(one - t)/one; rgb[2] = one - t;
			end
			SCH_JET: begin
				if (t*8 < one) rgb[2] = one/2 + 4*t;
				else if (t*8 < 3*one) begin
					rgb[1] = 4*t - one/2; rgb[2] = one;
				end else if (t*8 < 5*one) begin
					rgb[0] = 4*t - 3*one/2; rgb[1] = one; rgb[2] = one - rgb[0];
				end else if (t*8 < 7*one) begin
					rgb[0] = one; rgb[1] = one - (4*t - 5*one/2);
				end else rgb[0] = one - (4*t - 7*one/2);
			end
			default: begin
				n = (s == SCH_VIRIDIS) ? 11 : 9;
				pos = t * (n - 1);
				seg = pos >> FracBits;
				fr = pos & (one - 1);
				if (seg >= n - 1) begin
					seg = n - 2; fr = one;
				end
				for (int c = 0; c < 3; c++) begin
					a = tab_val(s, int'(seg), c);
					b = tab_val(s, int'(seg + 1), c);
					rgb[c] = (a*(one - fr) + b*fr + 500000) / 1000000;
				end
			end
		endcase
		res.idx = idx;
		res.r = (rgb[0] > 65535) ? 16'hFFFF : rgb[0][15:0];
		res.g = (rgb[1] > 65535) ? 16'hFFFF : rgb[1][15:0];
		res.b = (rgb[2] > 65535) ? 16'hFFFF : rgb[2][15:0];
		return res;
	endfunction

	// Register write while the pipeline is empty; mirror it into the predictor.
	task automatic write_reg(logic addr, logic [8:0] value);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_data <= value;
		@(negedge clk);
		if (addr == CFG_SCHEME) cur_scheme = scheme_t'(value[2:0]);
		else cur_count = value;
	endtask

	// Wait for every expected colour, then let the pipeline drain fully.
	task automatic drain;
		while (pending_colours.size() != 0) @(negedge clk);
		repeat (LATENCY + 2) @(negedge clk);
	endtask

	task automatic apply_setting(scheme_t s, logic [8:0] count);
		if (s == cur_scheme && count == cur_count) return;
		s_tvalid <= 1'b0;
		drain();
		write_reg(CFG_SCHEME, 9'(s));
		write_reg(CFG_COUNT, count);
		cfg_we <= 1'b0;
	endtask

	// Offer one request; idle one cycle beforehand at random, hold until accepted.
	task automatic send_request(logic [7:0] idx, colour_t want);
		if (!quiet_spell && $urandom_range(99) < 27) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= idx;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_colours.push_back(want);
		requests_sent++;
		@(negedge clk);
	endtask

	task automatic send_checked(logic [7:0] idx);
		send_request(idx, palette_colour(cur_scheme, cur_count, idx));
	endtask

	// Receiver: stall at random except during the quiet spell.
	always @(negedge clk)
		m_tready <= quiet_spell || ($urandom_range(99) >= 21);

	// Compare each accepted colour with the oldest expectation.
	always @(posedge clk) begin
		colour_t want, got;
		if (arst_n && m_tvalid && m_tready) begin
			got.idx = m_tdata[7:0];
			got.r = m_tdata[23:8];
			got.g = m_tdata[39:24];
			got.b = m_tdata[55:40];
			colours_seen++;
			if (pending_colours.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected colour: idx %0d rgb %h %h %h",
						got.idx, got.r, got.g, got.b);
			end else begin
				want = pending_colours.pop_front();
				if (want != got) begin
					mismatches++;
					if (mismatches <= 10)
						$display("colour mismatch: exp idx %0d rgb %h %h %h, got idx %0d rgb %h %h %h",
							want.idx, want.r, want.g, want.b,
							got.idx, got.r, got.g, got.b);
				end
			end
		end
	end

	// Watchdog on cycles with no handshake on either side.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("testbench: FAIL");
			$finish;
		end
	end

	initial begin
		row_t rows[$];
		colour_t want;
		scheme_t s;
		logic [8:0] cnt;
		int seg_len;
		// Reset defaults, extremes of count and index, every scheme.
		rows = '{
			'{SCH_GRAY, 9'd256, 8'd0,   1'b1, 16'h0000, 16'h0000, 16'h0000},
			'{SCH_GRAY, 9'd256, 8'd255, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF},
			'{SCH_GRAY, 9'd1,   8'd200, 1'b1, 16'h0000, 16'h0000, 16'h0000},
			'{SCH_GRAY, 9'd0,   8'd255, 1'b1, 16'h0000, 16'h0000, 16'h0000},
			'{SCH_GRAY, 9'd511, 8'd255, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF},
			'{SCH_GRAY, 9'd2,   8'd1,   1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF},
			'{SCH_GRAY, 9'd10,  8'd200, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF},
			'{SCH_HEAT, 9'd256, 8'd0,   1'b1, 16'h0000, 16'h0000, 16'h0000},
			'{SCH_HEAT, 9'd256, 8'd255, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF},
			'{SCH_HEAT, 9'd101, 8'd33,  1'b0, 0, 0, 0},
			'{SCH_HEAT, 9'd101, 8'd67,  1'b0, 0, 0, 0},
			'{SCH_COOLWARM, 9'd256, 8'd0,   1'b1, 16'h0000, 16'h0000, 16'hFFFF},
			'{SCH_COOLWARM, 9'd256, 8'd255, 1'b1, 16'hFFFF, 16'h0000, 16'h0000},
			'{SCH_COOLWARM, 9'd3,   8'd1,   1'b0, 0, 0, 0},
			'{SCH_JET, 9'd256, 8'd0,   1'b1, 16'h0000, 16'h0000, 16'h8000},
			'{SCH_JET, 9'd9,   8'd1,   1'b0, 0, 0, 0},
			'{SCH_JET, 9'd9,   8'd3,   1'b0, 0, 0, 0},
			'{SCH_JET, 9'd9,   8'd5,   1'b0, 0, 0, 0},
			'{SCH_JET, 9'd9,   8'd7,   1'b0, 0, 0, 0},
			'{SCH_JET, 9'd256, 8'd255, 1'b0, 0, 0, 0},
			'{SCH_VIRIDIS, 9'd256, 8'd0,   1'b0, 0, 0, 0},
			'{SCH_VIRIDIS, 9'd256, 8'd255, 1'b0, 0, 0, 0},
			'{SCH_PLASMA,  9'd256, 8'd128, 1'b0, 0, 0, 0},
			'{SCH_INFERNO, 9'd256, 8'd255, 1'b0, 0, 0, 0},
			'{SCH_TURBO,   9'd1,   8'd170, 1'b0, 0, 0, 0}
		};
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Walk the directed table; typed rows check against the table itself.
		foreach (rows[i]) begin
			apply_setting(rows[i].sch, rows[i].cnt);
			if (rows[i].chk) begin
				want.idx = rows[i].idx;
				want.r = rows[i].r;
				want.g = rows[i].g;
				want.b = rows[i].b;
				send_request(rows[i].idx, want);
			end else send_checked(rows[i].idx);
		end
		s_tvalid <= 1'b0;
		@(negedge clk);

		// Random phases: new setting, then a burst of indices; one burst
		// runs with no idling on either side to keep the pipeline full.
		for (int ph = 0; ph < 16; ph++) begin
			s = scheme_t'($urandom_range(7));
			case ($urandom_range(5))
				0: cnt = 9'd256;
				1: cnt = 9'($urandom_range(1, 2));
				2: cnt = 9'($urandom_range(257, 511));
				default: cnt = 9'($urandom_range(3, 255));
			endcase
			apply_setting(s, cnt);
			quiet_spell = (ph == 5);
			seg_len = 25;
			for (int k = 0; k < seg_len; k++) begin
				if ($urandom_range(9) == 0) send_checked(8'($urandom));
				else if (cnt >= 2 && cnt <= 256)
					send_checked(8'($urandom_range(0, cnt - 1)));
				else send_checked(8'($urandom));
			end
			s_tvalid <= 1'b0;
			quiet_spell = 1'b0;
			@(negedge clk);
		end

		drain();
		$display("covered %0d palette requests, %0d colours checked, all eight schemes",
			requests_sent, colours_seen);
		$display("counts from zero to above the maximum, %0d mismatches", mismatches);
		if (mismatches == 0 && pending_colours.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
